/* hdl/ght_pkg.sv */
// shared types and constants of the generational handle table
package ght_pkg;

   // table geometry
   localparam int SLOTS          = 16;
   localparam int SLOT_W         = $clog2(SLOTS);
   localparam int HANDLE_W       = 64;
   localparam int GEN_W          = HANDLE_W - SLOT_W;
   localparam int FILE_W         = 6;
   localparam int MAX_FILE_COUNT = 64;
   localparam int CNT_W          = 7;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 2;

   // a slot whose generation reaches this value is retired for good
   localparam logic [GEN_W-1:0] GEN_LIMIT = {GEN_W{1'b1}};

   // request codes
   typedef enum logic [1:0] {
      KIND_OPEN    = 2'd0,
      KIND_RESOLVE = 2'd1,
      KIND_CLOSE   = 2'd2,
      KIND_CLEAR   = 2'd3
   } kind_type;

   // reply codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_NO_SLOT   = 2'd2
   } status_type;

   // request transaction payload
   typedef struct packed {
      kind_type              kind;
      logic [HANDLE_W-1:0]   handle_in;
      logic [FILE_W-1:0]     file_in;
   } req_type;

   // reply transaction payload
   typedef struct packed {
      status_type            status;
      logic [HANDLE_W-1:0]   handle_out;
      logic [FILE_W-1:0]     file_out;
   } rsp_type;

   // write port of the slot memory
   typedef struct packed {
      logic                  en;
      logic [SLOT_W-1:0]     addr;
      logic [GEN_W-1:0]      gen;
      logic [FILE_W-1:0]     file;
   } slot_wr_type;

endpackage

/* hdl/ght_slot_mem.sv */
// slot memory holding generation and bound file of every slot
module ght_slot_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [ght_pkg::SLOT_W-1:0]  rd_addr,
   input  ght_pkg::slot_wr_type        wr,
   output logic [ght_pkg::GEN_W-1:0]   rd_gen,
   output logic [ght_pkg::FILE_W-1:0]  rd_file
);
   import ght_pkg::*;

   logic [GEN_W+FILE_W-1:0] mem_ff [SLOTS];
   logic [SLOTS-1:0]        written_ff;
   logic [SLOTS-1:0]        written_in;
   logic [GEN_W+FILE_W-1:0] rd_data_ff;
   logic                    rd_written_ff;

   // memory write port and registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= {wr.gen, wr.file};
      end
      if (rd_en) begin
         rd_data_ff    <= mem_ff[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   // per-entry written flags, an unwritten entry reads as generation zero
   always_comb begin
      written_in = written_ff;
      if (wr.en) begin
         written_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   // read data
   assign rd_gen  = rd_written_ff ? rd_data_ff[GEN_W+FILE_W-1:FILE_W] : '0;
   assign rd_file = rd_data_ff[FILE_W-1:0];

endmodule

/* hdl/generational_handle_table.sv */
// top level of the generational handle table
//
// In each transaction, the cycle in which start is taken reads the addressed
// slot from the slot memory, and the next cycle checks it, writes it back and registers the
// reply. busy is high during that checking cycle only, so a new start can be taken in the cycle
// the reply is shown. rsp_strobe is high for exactly one cycle per transaction, registered as the
// lookup state ends, and every transaction (open, resolve, close, clear all) gives exactly one
// reply. The reply cannot be held off. The table comes up ready right after reset; no clearing
// pass is needed. file_count is written over the csr port, which is always ready, and should be
// written only while no transaction is in flight.
module generational_handle_table (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            start,
   output logic                            busy,
   input  ght_pkg::req_type                req_data,
   // reply channel
   output logic                            rsp_strobe,
   output ght_pkg::rsp_type                rsp_data,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ght_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ght_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ght_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import ght_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

   localparam logic [CSR_ADDR_W-1:0] ADDR_FILE_COUNT = '0;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  file_count_ff, file_count_in;
   logic [SLOTS-1:0]  live_ff, live_in;
   logic [SLOTS-1:0]  retired_ff, retired_in;
   req_type           req_ff, req_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              free_ff, free_in;
   logic              file_ok_ff, file_ok_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              csr_write;
   logic [CNT_W-1:0]  eff_count;
   logic [SLOTS-1:0]  avail;
   logic [SLOT_W-1:0] free_slot;
   logic              free_any;
   slot_wr_type       wr;
   logic [GEN_W-1:0]  rd_gen;
   logic [FILE_W-1:0] rd_file;
   logic [GEN_W-1:0]  new_gen;
   logic              hit;

   assign busy      = (state_ff == ST_LOOKUP);
   assign accept    = start && !busy;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, file_count_ff};

   always_comb begin
      file_count_in = file_count_ff;
      if (csr_write && csr_paddr == ADDR_FILE_COUNT) begin
         file_count_in = csr_pwdata[CNT_W-1:0];
      end
   end

   // effective file count, capped at the volume maximum
   assign eff_count = (file_count_ff > CNT_W'(MAX_FILE_COUNT)) ? CNT_W'(MAX_FILE_COUNT)
                                                               : file_count_ff;

   // lowest slot that is neither live nor retired
   assign avail = ~live_ff & ~retired_ff;

   always_comb begin
      free_slot = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
   end

   assign free_any = |avail;

   // slot memory
   ght_slot_mem u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (slot_in),
      .wr      (wr),
      .rd_gen  (rd_gen),
      .rd_file (rd_file)
   );

   assign new_gen = rd_gen + GEN_W'(1);
   assign hit     = live_ff[slot_ff] && (rd_gen == req_ff.handle_in[HANDLE_W-1:SLOT_W]);

   // request capture, slot check and write back
   always_comb begin
      state_in      = state_ff;
      live_in       = live_ff;
      retired_in    = retired_ff;
      req_in        = req_ff;
      slot_in       = slot_ff;
      free_in       = free_ff;
      file_ok_in    = file_ok_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr            = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in     = req_data;
               slot_in    = (req_data.kind == KIND_OPEN) ? free_slot
                                                         : req_data.handle_in[SLOT_W-1:0];
               free_in    = free_any;
               file_ok_in = CNT_W'(req_data.file_in) < eff_count;
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in               = ST_IDLE;
            rsp_strobe_in          = 1'b1;
            rsp_data_in.status     = STATUS_OK;
            rsp_data_in.handle_out = '0;
            rsp_data_in.file_out   = '0;
            case (req_ff.kind)
               KIND_OPEN: begin
                  if (!file_ok_ff) begin
                     rsp_data_in.status = STATUS_NOT_FOUND;
                  end else if (!free_ff) begin
                     rsp_data_in.status = STATUS_NO_SLOT;
                  end else begin
                     wr.en                  = 1'b1;
                     wr.addr                = slot_ff;
                     wr.gen                 = new_gen;
                     wr.file                = req_ff.file_in;
                     live_in[slot_ff]       = 1'b1;
                     retired_in[slot_ff]    = (new_gen == GEN_LIMIT);
                     rsp_data_in.handle_out = {new_gen, slot_ff};
                  end
               end
               KIND_RESOLVE, KIND_CLOSE: begin
                  if (hit) begin
                     rsp_data_in.file_out = rd_file;
                     if (req_ff.kind == KIND_CLOSE) begin
                        live_in[slot_ff] = 1'b0;
                     end
                  end else begin
                     rsp_data_in.status = STATUS_NOT_FOUND;
                  end
               end
               KIND_CLEAR: begin
                  live_in = '0;
               end
               default: begin
                  live_in = live_ff;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         file_count_ff <= '0;
         live_ff       <= '0;
         retired_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         file_count_ff <= file_count_in;
         live_ff       <= live_in;
         retired_ff    <= retired_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      slot_ff     <= slot_in;
      free_ff     <= free_in;
      file_ok_ff  <= file_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

/* tb/testbench.sv */
// testbench of the generational handle table: directed and random transactions against a predictor
module testbench;
   import ght_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int SEG_ITEMS   = 300;
   localparam int SEGMENTS    = 6;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    start       = 1'b0;
   logic                    busy;
   req_type                 req_data    = '0;
   logic                    rsp_strobe;
   rsp_type                 rsp_data;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // predicted slot table and file count
   logic                    exp_live [SLOTS];
   logic [GEN_W-1:0]        exp_gen  [SLOTS];
   logic [FILE_W-1:0]       exp_file [SLOTS];
   logic [CNT_W-1:0]        exp_file_count;

   // replies still owed by the table, oldest first
   rsp_type                 pending_replies [$];

   int send_idle_pct   = 12;
   int fail_count      = 0;
   int items_sent      = 0;
   int replies_checked = 0;
   int settings_done   = 0;
   int stall_cycles    = 0;
   int status_seen [3] = '{0, 0, 0};

   generational_handle_table u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted reply of one transaction, updates the predicted table
   function automatic rsp_type predict_reply(req_type r);
      rsp_type             rsp;
      int                  eff;
      logic [SLOT_W-1:0]   s;
      rsp = '0;
      rsp.status = STATUS_OK;
      eff = (exp_file_count < MAX_FILE_COUNT) ? exp_file_count : MAX_FILE_COUNT;
      case (r.kind)
         KIND_OPEN: begin
            if (r.file_in >= eff) begin
               rsp.status = STATUS_NOT_FOUND;
            end else begin
               // lowest slot that is free and not retired
               rsp.status = STATUS_NO_SLOT;
               for (int i = 0; i < SLOTS; i++) begin
                  if (rsp.status == STATUS_NO_SLOT && !exp_live[i] && exp_gen[i] < GEN_LIMIT) begin
                     exp_gen[i]      = exp_gen[i] + 1'b1;
                     exp_file[i]     = r.file_in;
                     exp_live[i]     = 1'b1;
                     rsp.handle_out  = {exp_gen[i], SLOT_W'(i)};
                     rsp.status      = STATUS_OK;
                  end
               end
            end
         end
         KIND_RESOLVE, KIND_CLOSE: begin
            s = r.handle_in[SLOT_W-1:0];
            if (exp_live[s] && exp_gen[s] == r.handle_in[HANDLE_W-1:SLOT_W]) begin
               rsp.file_out = exp_file[s];
               if (r.kind == KIND_CLOSE) begin
                  exp_live[s] = 1'b0;
               end
            end else begin
               rsp.status = STATUS_NOT_FOUND;
            end
         end
         default: begin
            for (int i = 0; i < SLOTS; i++) begin
               exp_live[i] = 1'b0;
            end
         end
      endcase
      return rsp;
   endfunction

   function automatic req_type make_req(kind_type k, logic [HANDLE_W-1:0] h,
                                        logic [FILE_W-1:0] f);
      req_type r;
      r.kind      = k;
      r.handle_in = h;
      r.file_in   = f;
      return r;
   endfunction

   // mostly well-formed traffic: valid opens, lookups of live handles, some noise
   function automatic req_type random_request();
      req_type            r;
      int                 eff;
      int                 pick;
      int                 sel;
      int                 s;
      int                 live_slots [$];
      logic [GEN_W-1:0]   g;
      r.kind      = KIND_CLEAR;
      r.handle_in = {$urandom, $urandom};
      r.file_in   = FILE_W'($urandom_range(63));
      pick        = $urandom_range(99);
      if (pick < 40) begin
         r.kind = KIND_OPEN;
         eff = (exp_file_count < MAX_FILE_COUNT) ? exp_file_count : MAX_FILE_COUNT;
         if (eff > 0 && $urandom_range(9) != 0) begin
            r.file_in = FILE_W'($urandom_range(eff - 1));
         end
      end else if (pick < 97) begin
         r.kind = (pick < 70) ? KIND_RESOLVE : KIND_CLOSE;
         for (int i = 0; i < SLOTS; i++) begin
            if (exp_live[i]) begin
               live_slots.push_back(i);
            end
         end
         sel = $urandom_range(99);
         s   = $urandom_range(SLOTS - 1);
         if (sel < 70 && live_slots.size() > 0) begin
            s = live_slots[$urandom_range(live_slots.size() - 1)];
            r.handle_in = {exp_gen[s], SLOT_W'(s)};
         end else if (sel < 80) begin
            // current generation of a slot that is usually not live
            r.handle_in = {exp_gen[s], SLOT_W'(s)};
         end else if (sel < 90) begin
            // stale or future generation
            g = $urandom_range(1) ? exp_gen[s] + 1'b1 : exp_gen[s] - 1'b1;
            r.handle_in = {g, SLOT_W'(s)};
         end
      end
      return r;
   endfunction

   // send one transaction; start stays high afterwards so back-to-back sends keep it high
   task automatic send_request(req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pending_replies.push_back(predict_reply(r));
      items_sent++;
   endtask

   // hold off until every owed reply has come back
   task automatic wait_for_replies();
      @(negedge clock);
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // write file_count while idle, then read it back
   task automatic write_file_count(logic [CSR_DATA_W-1:0] word);
      logic [CSR_DATA_W-1:0] got;
      wait_for_replies();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= '0;
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      exp_file_count = word[CNT_W-1:0];
      // read back in the next transfer
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== CSR_DATA_W'(exp_file_count)) begin
         $error("csr_prdata expected %0d actual %0d", exp_file_count, got);
         fail_count++;
      end
      settings_done++;
   endtask

   // lookups and opens against an empty table with no files
   task automatic test_empty_table();
      write_file_count('0);
      send_request(make_req(KIND_OPEN, '0, 6'd0));
      send_request(make_req(KIND_RESOLVE, '0, '1));
      send_request(make_req(KIND_CLOSE, {{GEN_W{1'b0}}, {SLOT_W{1'b1}}}, '0));
   endtask

   // basic open, resolve and close, with generation and handle misses
   task automatic test_open_resolve_close();
      logic [HANDLE_W-1:0] first;
      write_file_count(32'd64);
      send_request(make_req(KIND_OPEN, '1, 6'd63));
      first = {exp_gen[0], {SLOT_W{1'b0}}};
      send_request(make_req(KIND_OPEN, '0, 6'd0));
      send_request(make_req(KIND_RESOLVE, first, '0));
      send_request(make_req(KIND_RESOLVE, {exp_gen[0] + 1'b1, {SLOT_W{1'b0}}}, '0));
      send_request(make_req(KIND_RESOLVE, '1, '1));
      send_request(make_req(KIND_CLOSE, first, '0));
      send_request(make_req(KIND_RESOLVE, first, '0));
   endtask

   // fill every slot, overflow, then clear all
   task automatic test_table_full();
      logic [HANDLE_W-1:0] last;
      repeat (SLOTS) begin
         send_request(make_req(KIND_OPEN, {$urandom, $urandom},
                               FILE_W'($urandom_range(63))));
      end
      last = {exp_gen[SLOTS-1], {SLOT_W{1'b1}}};
      send_request(make_req(KIND_RESOLVE, last, '0));
      send_request(make_req(KIND_CLEAR, {$urandom, $urandom}, FILE_W'($urandom_range(63))));
      send_request(make_req(KIND_RESOLVE, last, '0));
      send_request(make_req(KIND_OPEN, '0, 6'd17));
   endtask

   // random traffic over several file_count settings and sender idle rates
   // (retiring a slot at the generation limit needs far more opens than any run)
   task automatic test_random_traffic();
      logic [CSR_DATA_W-1:0] word;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         send_idle_pct = (seg < 2) ? 12 : (seg < 4) ? 51 : 0;
         case (seg)
            0:       word = 32'd1;
            1:       word = 32'd63;
            2:       word = ($urandom & ~32'h7f) | 32'd127;
            3:       word = $urandom_range(62, 2);
            4:       word = 32'd64;
            default: word = $urandom_range(127);
         endcase
         write_file_count(word);
         repeat (SEG_ITEMS) begin
            send_request(random_request());
            if ($urandom_range(149) == 0) begin
               wait_for_replies();
            end
         end
      end
   endtask

   // reply checker
   always @(posedge clock) begin : reply_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            $error("reply with no transaction outstanding: %h", rsp_data);
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            replies_checked++;
            status_seen[want.status]++;
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.handle_out !== want.handle_out) begin
               $error("handle_out expected %h actual %h", want.handle_out, rsp_data.handle_out);
               fail_count++;
            end
            if (rsp_data.file_out !== want.file_out) begin
               $error("file_out expected %0d actual %0d", want.file_out, rsp_data.file_out);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction, reply or register access
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_psel && csr_penable)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // test sequence
   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         exp_live[i] = 1'b0;
         exp_gen[i]  = '0;
         exp_file[i] = '0;
      end
      exp_file_count = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_open_resolve_close();
      test_table_full();
      test_random_traffic();
      wait_for_replies();

      $display("%0d transactions, %0d replies checked over %0d file_count settings",
               items_sent, replies_checked, settings_done);
      $display("replies: %0d ok, %0d not found, %0d no free slot",
               status_seen[STATUS_OK], status_seen[STATUS_NOT_FOUND], status_seen[STATUS_NO_SLOT]);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
